[hdl/running_mean_variance_defines.svh]
// ----------------------------------------------------------------------------
// running_mean_variance assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef RUNNING_MEAN_VARIANCE_DEFINES_SVH
`define RUNNING_MEAN_VARIANCE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define RMV_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("running_mean_variance: assertion failed");
// next-cycle implication
`define RMV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("running_mean_variance: assertion failed");
`else
`define RMV_ASSERT(label, clk, rst_n, ante, cons)
`define RMV_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[hdl/rmv_pkg.sv]
// ----------------------------------------------------------------------------
// rmv_pkg
// shared types and constants of the running mean / variance block
// ----------------------------------------------------------------------------
`default_nettype none

package rmv_pkg;

    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF    = 16;

    localparam int SAMPLE_W = 32;
    localparam int MEAN_W   = 48;
    localparam int VAR_W    = 64;
    localparam int COUNT_W  = 32;
    localparam int DIV_W    = 64;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                restart;
    } item_t;

    typedef struct packed {
        logic [MEAN_W-1:0]  mean;
        logic [VAR_W-1:0]   variance;
        logic [COUNT_W-1:0] sample_count;
    } result_t;

    // divider status toward the sequencer
    typedef struct packed {
        logic done;
        logic sat;
        logic rem_nz;
    } div_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV1,
        ST_UPD,
        ST_MUL,
        ST_DIV2
    } state_t;

endpackage

`default_nettype wire

[hdl/rmv_div.sv]
// ----------------------------------------------------------------------------
// rmv_div
// restoring divider, 128-bit dividend by 64-bit divisor, one quotient bit
// per cycle; quotient saturates to all ones when it would exceed 64 bits
// ----------------------------------------------------------------------------
`default_nettype none

module rmv_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [rmv_pkg::DIV_W-1:0]   num_hi,
    input  wire logic [rmv_pkg::DIV_W-1:0]   num_lo,
    input  wire logic [rmv_pkg::DIV_W-1:0]   den,
    output logic      [rmv_pkg::DIV_W-1:0]   quot,
    output rmv_pkg::div_stat_t               stat
);

    localparam int DW    = rmv_pkg::DIV_W;
    localparam int CNT_W = $clog2(DW);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DW - 1);

    logic             busy_reg;
    logic             done_reg;
    logic             sat_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    lo_reg;
    logic [DW-1:0]    den_reg;
    logic [DW-1:0]    quot_reg;

    logic [DW:0]      trial;
    logic [DW:0]      diff;
    logic             fits;
    logic [DW-1:0]    rem_next;

    // shift in the next dividend bit, the bit above bit 63 acts as carry
    always_comb
    begin
        trial    = {rem_reg, lo_reg[DW-1]};
        diff     = trial - {1'b0, den_reg};
        fits     = (trial >= {1'b0, den_reg});
        rem_next = fits ? diff[DW-1:0] : trial[DW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            sat_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            // high half not below divisor: quotient overflows
            if (num_hi >= den)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
                sat_reg  <= 1'b1;
            end
            else
            begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                sat_reg  <= 1'b0;
            end
            cnt_reg <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= num_hi;
            lo_reg   <= num_lo;
            den_reg  <= den;
            quot_reg <= (num_hi >= den) ? '1 : '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            lo_reg   <= {lo_reg[DW-2:0], 1'b0};
            quot_reg <= {quot_reg[DW-2:0], fits};
        end
    end

    assign quot        = quot_reg;
    assign stat.done   = done_reg;
    assign stat.sat    = sat_reg;
    assign stat.rem_nz = (rem_reg != '0);

endmodule

`default_nettype wire

[hdl/rmv_mul.sv]
// ----------------------------------------------------------------------------
// rmv_mul
// shift-and-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module rmv_mul #(
    parameter int W = rmv_pkg::SAMPLE_WIDTH_DEF + rmv_pkg::FRAC_BITS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [W-1:0]   a,
    input  wire logic [W-1:0]   b,
    output logic      [2*W-1:0] prod,
    output logic                done
);

    localparam int CNT_W = (W > 1) ? $clog2(W) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     a_reg;
    logic [2*W-1:0]   acc_reg;

    logic [W:0]       sum;
    logic [2*W-1:0]   acc_next;

    // upper half accumulates, lower half shifts the multiplier out
    always_comb
    begin
        sum      = {1'b0, acc_reg[2*W-1:W]} + (acc_reg[0] ? {1'b0, a_reg} : '0);
        acc_next = {sum, acc_reg[W-1:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            acc_reg <= {{W{1'b0}}, b};
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign prod = acc_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

[hdl/running_mean_variance.sv]
// ----------------------------------------------------------------------------
// running_mean_variance
// sequence: setup, then two 64-step serial divisions side by side, the update, the
//   bit-serial multiply and the term2 division, which ends early when it saturates
// a new request is taken only once the previous one has finished; the final step
//   also waits while an earlier result is still waiting in the output register
// reset: rst_n clears count, mean and variance to zero and empties the output
// ----------------------------------------------------------------------------
`default_nettype none

`include "running_mean_variance_defines.svh"

module running_mean_variance #(
    parameter int SAMPLE_WIDTH = rmv_pkg::SAMPLE_WIDTH_DEF,
    parameter int FRAC_BITS    = rmv_pkg::FRAC_BITS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    // request channel
    input  wire logic             item_valid,
    output logic                  item_ready,
    input  wire rmv_pkg::item_t   item,
    // result channel
    output logic                  result_valid,
    input  wire logic             result_ready,
    output rmv_pkg::result_t      result
);

    // width of a sample in fixed point, also bounds mean and |x - mean|
    localparam int XW      = SAMPLE_WIDTH + FRAC_BITS;
    localparam int DW      = rmv_pkg::DIV_W;
    localparam int PROD_W  = 2 * DW;
    localparam int COUNT_W = rmv_pkg::COUNT_W;
    localparam int MEAN_W  = rmv_pkg::MEAN_W;

    // ------------------------------------------------------------------
    // architectural state and request / result registers
    // ------------------------------------------------------------------
    rmv_pkg::state_t           state_reg, state_next;
    logic [COUNT_W-1:0]        count_reg;
    logic [MEAN_W-1:0]         mean_reg;
    logic [DW-1:0]             var_reg;

    logic [SAMPLE_WIDTH-1:0]   samp_reg;
    logic                      restart_reg;
    logic [COUNT_W-1:0]        k_reg;
    logic [XW-1:0]             d_reg;
    logic                      up_reg;
    logic [XW-1:0]             mean_upd_reg;
    logic [DW-1:0]             term1_reg;

    rmv_pkg::result_t          result_reg;
    logic                      result_valid_reg;

    // ------------------------------------------------------------------
    // sequencer controls
    // ------------------------------------------------------------------
    logic accept;
    logic diva_start;
    logic divb_start;
    logic mul_start;
    logic setup_en;
    logic upd_en;
    logic fin_en;
    logic out_free;

    // ------------------------------------------------------------------
    // datapath nets
    // ------------------------------------------------------------------
    logic [XW-1:0]             x_val;
    logic [XW-1:0]             mean_lo;
    logic                      x_ge;
    logic [XW-1:0]             d_val;
    logic [COUNT_W-1:0]        count_base;
    logic [COUNT_W-1:0]        k_val;

    logic [DW-1:0]             diva_hi;
    logic [DW-1:0]             diva_lo;
    logic [DW-1:0]             diva_den;
    logic [DW-1:0]             diva_quot;
    logic [DW-1:0]             divb_quot;
    rmv_pkg::div_stat_t        diva_stat;
    rmv_pkg::div_stat_t        divb_stat;

    logic [XW-1:0]             q_val;
    logic [XW-1:0]             p_val;
    logic [XW-1:0]             mean_upd_next;
    logic [DW-1:0]             term1_next;

    logic [2*XW-1:0]           mul_prod;
    logic                      mul_done;
    logic [PROD_W-1:0]         prod_wide;

    logic [DW:0]               var_sum;
    logic [DW-1:0]             var_new;

    // ------------------------------------------------------------------
    // setup: k and |x - mean| from the current state
    // a restart only drops the count; with k = 1 the old mean and
    // variance fall out of the update on their own
    // ------------------------------------------------------------------
    always_comb
    begin
        x_val      = XW'(samp_reg) << FRAC_BITS;
        mean_lo    = mean_reg[XW-1:0];
        x_ge       = (x_val >= mean_lo);
        d_val      = x_ge ? (x_val - mean_lo) : (mean_lo - x_val);
        count_base = restart_reg ? '0 : count_reg;
        // count sticks at its maximum, k then equals the maximum too
        k_val      = (count_base == rmv_pkg::COUNT_MAX) ? rmv_pkg::COUNT_MAX
                                                        : count_base + 1'b1;
    end

    // ------------------------------------------------------------------
    // update: floor(a*(k-1)/k) = a - ceil(a/k), so one division per
    // operand gives both the mean step and the scaled terms
    //   q     = d / k
    //   mean  = mean +/- q
    //   p     = d - ceil(d/k)           = floor(d*(k-1)/k)
    //   term1 = var - ceil(var/k)       = floor(var*(k-1)/k)
    // ------------------------------------------------------------------
    always_comb
    begin
        q_val         = diva_quot[XW-1:0];
        mean_upd_next = up_reg ? (mean_lo + q_val) : (mean_lo - q_val);
        p_val         = d_reg - q_val - XW'(diva_stat.rem_nz);
        term1_next    = var_reg - divb_quot - DW'(divb_stat.rem_nz);
    end

    // ------------------------------------------------------------------
    // final: term2 = floor(p*d / (k << FRAC_BITS)), saturating sum
    // ------------------------------------------------------------------
    always_comb
    begin
        var_sum = {1'b0, term1_reg} + {1'b0, diva_quot};
        var_new = var_sum[DW] ? '1 : var_sum[DW-1:0];
    end

    // divider A serves d / k first and the term2 division later
    assign prod_wide = PROD_W'(mul_prod);

    always_comb
    begin
        if (state_reg == rmv_pkg::ST_MUL)
        begin
            diva_hi  = prod_wide[PROD_W-1:DW];
            diva_lo  = prod_wide[DW-1:0];
            diva_den = DW'(k_reg) << FRAC_BITS;
        end
        else
        begin
            diva_hi  = '0;
            diva_lo  = DW'(d_val);
            diva_den = DW'(k_val);
        end
    end

    rmv_div u_div_a (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (diva_start),
        .num_hi (diva_hi),
        .num_lo (diva_lo),
        .den    (diva_den),
        .quot   (diva_quot),
        .stat   (diva_stat)
    );

    // divider B only runs var / k, alongside the first pass of A
    rmv_div u_div_b (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (divb_start),
        .num_hi ('0),
        .num_lo (var_reg),
        .den    (DW'(k_val)),
        .quot   (divb_quot),
        .stat   (divb_stat)
    );

    rmv_mul #(
        .W (XW)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (p_val),
        .b     (d_reg),
        .prod  (mul_prod),
        .done  (mul_done)
    );

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    assign out_free = !result_valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rmv_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        accept     = 1'b0;
        diva_start = 1'b0;
        divb_start = 1'b0;
        mul_start  = 1'b0;
        setup_en   = 1'b0;
        upd_en     = 1'b0;
        fin_en     = 1'b0;
        unique case (state_reg)
            rmv_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    accept     = 1'b1;
                    state_next = rmv_pkg::ST_SETUP;
                end
            end
            rmv_pkg::ST_SETUP:
            begin
                setup_en   = 1'b1;
                diva_start = 1'b1;
                divb_start = 1'b1;
                state_next = rmv_pkg::ST_DIV1;
            end
            rmv_pkg::ST_DIV1:
            begin
                if (diva_stat.done && divb_stat.done)
                begin
                    state_next = rmv_pkg::ST_UPD;
                end
            end
            rmv_pkg::ST_UPD:
            begin
                upd_en     = 1'b1;
                mul_start  = 1'b1;
                state_next = rmv_pkg::ST_MUL;
            end
            rmv_pkg::ST_MUL:
            begin
                if (mul_done)
                begin
                    diva_start = 1'b1;
                    state_next = rmv_pkg::ST_DIV2;
                end
            end
            rmv_pkg::ST_DIV2:
            begin
                // hold the finished sum until the output register frees up
                if (diva_stat.done && out_free)
                begin
                    fin_en     = 1'b1;
                    state_next = rmv_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rmv_pkg::ST_IDLE;
            end
        endcase
    end

    assign item_ready = (state_reg == rmv_pkg::ST_IDLE);

    // ------------------------------------------------------------------
    // architectural state and result valid
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            mean_reg         <= '0;
            var_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (fin_en)
            begin
                count_reg <= k_reg;
                mean_reg  <= MEAN_W'(mean_upd_reg);
                var_reg   <= var_new;
            end
            if (fin_en)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // working registers, no reset needed
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            samp_reg    <= item.sample[SAMPLE_WIDTH-1:0];
            restart_reg <= item.restart;
        end
        if (setup_en)
        begin
            k_reg  <= k_val;
            d_reg  <= d_val;
            up_reg <= x_ge;
        end
        if (upd_en)
        begin
            mean_upd_reg <= mean_upd_next;
            term1_reg    <= term1_next;
        end
        if (fin_en)
        begin
            result_reg.mean         <= MEAN_W'(mean_upd_reg);
            result_reg.variance     <= var_new;
            result_reg.sample_count <= k_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // a delivered result always counts at least one sample
    `RMV_ASSERT(a_result_count, clk, rst_n, result_valid_reg, result_reg.sample_count != '0)
    // the mean stays within the fixed-point sample range
    `RMV_ASSERT(a_mean_range, clk, rst_n, 1'b1, (mean_reg >> XW) == '0)
    // both dividers run the first pass in lockstep
    `RMV_ASSERT(a_div_lockstep, clk, rst_n, state_reg == rmv_pkg::ST_DIV1, diva_stat.done == divb_stat.done)
    // divisions by k never overflow the quotient
    `RMV_ASSERT(a_div_no_sat, clk, rst_n, state_reg == rmv_pkg::ST_UPD, !diva_stat.sat && !divb_stat.sat)
    // the first sample of a series leaves zero variance
    `RMV_ASSERT_NEXT(a_first_var, clk, rst_n, fin_en && (k_reg == COUNT_W'(1)), var_reg == '0)

endmodule

`default_nettype wire
